FILE: sv/bdac_pkg.sv
// Shared types and constants for the binary to decimal ASCII converter.
`default_nettype none

package bdac_pkg;

  // Front-end conversion sequencer states.
  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } front_state_t;

  // ASCII code of the character '0', reduced to the 6-bit character field.
  localparam logic [5:0] ASCII_ZERO = 6'd48;

  // Shift-and-add-3 correction: a BCD digit of five or more gets three added.
  localparam logic [3:0] DIGIT_ADJ_MIN = 4'd5;
  localparam logic [3:0] DIGIT_ADJ_ADD = 4'd3;

endpackage

`default_nettype wire

FILE: sv/bdac_front.sv
// Front end: accepts a binary value and converts it to BCD one bit per cycle.
`default_nettype none

module bdac_front #(
  parameter int VALUE_BITS = 32,
  parameter int NDIG       = 10,
  parameter int IW         = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [31:0]                in_value,
  output logic                            push_valid,
  input  wire logic                       push_ready,
  output logic [IW+4*NDIG-1:0]            push_data
);
  import bdac_pkg::*;

  localparam int CNTW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam logic [CNTW-1:0] LAST_BIT = CNTW'(VALUE_BITS - 1);

  front_state_t            state_r, state_nxt;
  logic [VALUE_BITS-1:0]   shr_r, shr_nxt;
  logic [4*NDIG-1:0]       bcd_r, bcd_nxt;
  logic [CNTW-1:0]         cnt_r, cnt_nxt;
  logic [4*NDIG-1:0]       bcd_adj;
  logic [IW-1:0]           top_idx;
  logic                    in_xfer;
  logic                    push_xfer;

  assign in_xfer   = in_valid && in_ready;
  assign push_xfer = push_valid && push_ready;

  // Next-state logic of the conversion sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (in_xfer) state_nxt = F_CONV;
      end
      F_CONV: begin
        if (cnt_r == LAST_BIT) state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (push_xfer) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // Handshake outputs decoded from the state.
  always_comb begin
    in_ready   = 1'b0;
    push_valid = 1'b0;
    case (state_r)
      F_IDLE:  in_ready   = 1'b1;
      F_CONV:  ;
      F_PUSH:  push_valid = 1'b1;
      default: ;
    endcase
  end

  // Add three to every digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[4*i +: 4] >= DIGIT_ADJ_MIN) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + DIGIT_ADJ_ADD;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  // Datapath: load on a transfer, then shift one input bit into the BCD word per cycle.
  always_comb begin
    shr_nxt = shr_r;
    bcd_nxt = bcd_r;
    cnt_nxt = cnt_r;
    if (in_xfer) begin
      shr_nxt = in_value[VALUE_BITS-1:0];
      bcd_nxt = '0;
      cnt_nxt = '0;
    end else if (state_r == F_CONV) begin
      shr_nxt = {shr_r[VALUE_BITS-2:0], 1'b0};
      bcd_nxt = {bcd_adj[4*NDIG-2:0], shr_r[VALUE_BITS-1]};
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  // Position of the most significant nonzero digit; zero gives position zero.
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[4*i +: 4] != 4'd0) top_idx = IW'(i);
    end
  end

  assign push_data = {top_idx, bcd_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shr_r <= shr_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule

`default_nettype wire

FILE: sv/bdac_fifo.sv
// Short queue of converted values between the front end and the digit emitter.
`default_nettype none

module bdac_fifo #(
  parameter int WIDTH = 44,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [AW:0]      cnt_r;
  logic             push_xfer, pop_xfer;

  assign push_ready = (cnt_r != (AW + 1)'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push_xfer  = push_valid && push_ready;
  assign pop_xfer   = pop_valid && pop_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_xfer) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_xfer) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_xfer && !pop_xfer) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop_xfer && !push_xfer) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push_xfer) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

`default_nettype wire

FILE: sv/bdac_back.sv
// Back end: emits the digits of one converted value, most significant first.
`default_nettype none

module bdac_back #(
  parameter int NDIG = 10,
  parameter int IW   = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  pop_valid,
  output logic                       pop_ready,
  input  wire logic [IW+4*NDIG-1:0]  pop_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [5:0]                 out_digit_char,
  output logic                       out_last
);
  import bdac_pkg::*;

  logic                busy_r;
  logic [IW-1:0]       idx_r;
  logic [4*NDIG-1:0]   bcd_r;
  logic [3:0]          digit;
  logic                out_xfer;
  logic                load;

  assign out_valid      = busy_r;
  assign digit          = bcd_r[{idx_r, 2'b00} +: 4];
  assign out_digit_char = ASCII_ZERO + {2'b00, digit};
  assign out_last       = (idx_r == '0);
  assign out_xfer       = out_valid && out_ready;

  // Take a new value once the current one has sent its final digit.
  assign pop_ready = !busy_r || (out_xfer && out_last);
  assign load      = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (load) begin
      busy_r <= 1'b1;
    end else if (out_xfer && out_last) begin
      busy_r <= 1'b0;
    end
  end

  // Digit index counts down toward the least significant digit.
  always_ff @(posedge clk) begin
    if (load) begin
      idx_r <= pop_data[IW+4*NDIG-1 -: IW];
      bcd_r <= pop_data[4*NDIG-1:0];
    end else if (out_xfer && !out_last) begin
      idx_r <= idx_r - 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: sv/binary_to_decimal_ascii_top.sv
// Top level of the binary to decimal ASCII converter.
`default_nettype none

// Converts an unsigned binary value (low VALUE_BITS bits of in_value) into its
// decimal text: one ASCII digit per output transfer, most significant first,
// no leading zeros, and out_last high on the final digit; zero gives a lone '0'.
// The front end runs a shift-and-add-3 conversion that handles one input bit
// per cycle, pushes the result into the queue, and only then returns to idle to
// take its next value. The queue holds two converted values, and the back end
// sends one character per cycle while out_ready is high, so the next value can
// be converted while the digits of a value leave.
module binary_to_decimal_ascii_top #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [5:0]       out_digit_char,
  output logic             out_last
);

  // Decimal digits needed for the largest VALUE_BITS-bit value.
  localparam int NDIG = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int IW   = $clog2(NDIG);
  localparam int QW   = IW + 4 * NDIG;

  logic          push_valid, push_ready;
  logic [QW-1:0] push_data;
  logic          pop_valid, pop_ready;
  logic [QW-1:0] pop_data;

  bdac_front #(
    .VALUE_BITS (VALUE_BITS),
    .NDIG       (NDIG),
    .IW         (IW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_value   (in_value),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  bdac_fifo #(
    .WIDTH (QW),
    .DEPTH (2)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  bdac_back #(
    .NDIG (NDIG),
    .IW   (IW)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_data       (pop_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_digit_char (out_digit_char),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

FILE: sv/bdac_checker.sv
// Port-level checks for the binary to decimal ASCII converter, bound to the top level.
`default_nettype none

module bdac_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [5:0] out_digit_char,
  input wire logic       out_last
);

  // High while the next output transfer opens a new number.
  logic first_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
    end else if (out_valid && out_ready) begin
      first_r <= out_last;
    end
  end

  // A stalled character holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digit_char) && $stable(out_last))
    else $error("output changed while stalled");

  // Every character is a decimal digit.
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_char >= 6'd48) && (out_digit_char <= 6'd57))
    else $error("character is not a decimal digit");

  // A number never opens with a zero unless that zero is the whole number.
  a_no_lead_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && first_r && (out_digit_char == 6'd48) |-> out_last)
    else $error("leading zero emitted");

  // Within a number the digits follow one another without a gap.
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("gap inside a number");

endmodule

bind binary_to_decimal_ascii_top bdac_checker u_bdac_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_digit_char (out_digit_char),
  .out_last       (out_last)
);

`default_nettype wire

FILE: tb/decimal_text_checker.sv
// Checker that predicts and compares the decimal text produced for each input value.
module decimal_text_checker
  import bdac_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] in_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [5:0]  out_digit_char,
  input  logic        out_last,
  output int          error_count,
  output int          chars_pending,
  output int          values_seen,
  output int          chars_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // One expected character of the decimal text.
  typedef struct packed {
    logic [5:0] digit_char;
    logic       last;
  } text_char_t;

  localparam logic [63:0] VALUE_MASK = (64'd1 << VALUE_BITS) - 64'd1;
  localparam int MAX_REPORTS = 30;

  text_char_t pending_chars[$];

  initial begin
    error_count   = 0;
    chars_pending = 0;
    values_seen   = 0;
    chars_seen    = 0;
  end

  // Appends the decimal characters of one value, most significant digit first.
  function automatic void queue_decimal_chars(input logic [31:0] raw);
    logic [31:0] num;
    logic [3:0]  rev_digits [10];
    text_char_t  ch;
    int          count;
    int          k;
    num   = raw & VALUE_MASK[31:0];
    count = 0;
    if (num == 32'd0) begin
      rev_digits[0] = 4'd0;
      count = 1;
    end
    while (num != 32'd0 && count < 10) begin
      rev_digits[count] = 4'(num % 32'd10);
      num = num / 32'd10;
      count++;
    end
    for (k = count - 1; k >= 0; k--) begin
      ch.digit_char = ASCII_ZERO + 6'(rev_digits[k]);
      ch.last       = (k == 0);
      pending_chars.push_back(ch);
    end
  endfunction

  // Watch both channels: predict on each input transfer, compare on each output transfer.
  always @(posedge clk) begin
    text_char_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        queue_decimal_chars(in_value);
        values_seen++;
      end
      if (out_valid && out_ready) begin
        chars_seen++;
        if (pending_chars.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: unexpected character transfer: char=%0d last=%0b",
                     $time, out_digit_char, out_last);
        end else begin
          want = pending_chars.pop_front();
          if (out_digit_char !== want.digit_char) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("%0t: digit_char mismatch: expected %0d, actual %0d",
                       $time, want.digit_char, out_digit_char);
          end
          if (out_last !== want.last) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("%0t: last mismatch: expected %0b, actual %0b",
                       $time, want.last, out_last);
          end
        end
      end
      chars_pending = pending_chars.size();
    end
  end

endmodule

FILE: tb/tb.sv
// Testbench top for the binary to decimal ASCII converter: stimulus, sink and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_BITS    = 32;
  localparam int RANDOM_VALUES = 480;
  localparam int QUIET_TAIL    = 60;
  localparam int HOLD_CYCLES   = 600;
  localparam int CYCLE_LIMIT   = 1000000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_value;
  logic        out_valid;
  logic        out_ready;
  logic [5:0]  out_digit_char;
  logic        out_last;

  int error_count;
  int chars_pending;
  int values_seen;
  int chars_seen;
  int values_sent;
  int cycle_count;
  bit quiet;

  logic [31:0] corner_values [23] = '{
    32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd999, 32'd1000,
    32'd65535, 32'd65536, 32'd99999999, 32'd100000000, 32'd999999999,
    32'd1000000000, 32'd2147483647, 32'd2147483648, 32'd4294967295,
    32'd4294967294, 32'hAAAAAAAA, 32'h55555555, 32'd1234567890, 32'd4000000000
  };

  binary_to_decimal_ascii_top #(
    .VALUE_BITS(VALUE_BITS)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_digit_char(out_digit_char),
    .out_last      (out_last)
  );

  decimal_text_checker #(
    .VALUE_BITS(VALUE_BITS)
  ) checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_digit_char(out_digit_char),
    .out_last      (out_last),
    .error_count   (error_count),
    .chars_pending (chars_pending),
    .values_seen   (values_seen),
    .chars_seen    (chars_seen)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d characters outstanding",
             cycle_count, chars_pending);
    $display("** binary_to_decimal_ascii_top: FAILED **");
    $finish;
  end

  // Random value, biased toward every digit count and toward powers of ten.
  function automatic logic [31:0] random_value();
    logic [31:0] low_bound;
    logic [31:0] high_bound;
    int          digits;
    int          k;
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom();
      3: begin
        low_bound = 32'd1;
        for (k = $urandom_range(0, 9); k > 0; k--)
          low_bound = low_bound * 32'd10;
        return low_bound + 32'($urandom_range(0, 2)) - 32'd1;
      end
      default: begin
        digits    = $urandom_range(1, 10);
        low_bound = 32'd1;
        for (k = 1; k < digits; k++)
          low_bound = low_bound * 32'd10;
        high_bound = (digits == 10) ? 32'hFFFFFFFF : low_bound * 32'd10 - 32'd1;
        if (digits == 1)
          low_bound = 32'd0;
        return $urandom_range(high_bound, low_bound);
      end
    endcase
  endfunction

  // Offer one value, with an optional random gap first, and wait for its transfer.
  task automatic send_value(input logic [31:0] value);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    values_sent++;
  endtask

  // Receiver: random stall bursts, one long hold to back the block up, none at the end.
  initial begin
    bit held;
    int hold;
    held = 1'b0;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!held && values_sent >= 120) begin
        held = 1'b1;
        out_ready <= 1'b0;
        for (hold = 0; hold < HOLD_CYCLES; hold++) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Reset, corner values, random values, drain and verdict.
  initial begin
    int i;
    values_sent = 0;
    quiet       = 1'b0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_value <= 32'd0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < 23; i++)
      send_value(corner_values[i]);

    for (i = 0; i < RANDOM_VALUES; i++) begin
      if (i >= RANDOM_VALUES - QUIET_TAIL)
        quiet = 1'b1;
      send_value(random_value());
    end
    in_valid <= 1'b0;

    // Drain whatever text is still in flight.
    while (chars_pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Converted %0d values into %0d checked digit characters,", values_seen,
             chars_seen);
    $display("with random stalls on both channels and a %0d-cycle receiver hold.",
             HOLD_CYCLES);
    if (error_count == 0 && chars_pending == 0) begin
      $display("** binary_to_decimal_ascii_top: PASSED **");
    end else begin
      $display("** binary_to_decimal_ascii_top: FAILED **");
    end
    $finish;
  end

endmodule

FILE: binary_to_decimal_ascii_top.f
sv/bdac_pkg.sv
sv/bdac_front.sv
sv/bdac_fifo.sv
sv/bdac_back.sv
sv/binary_to_decimal_ascii_top.sv
sv/bdac_checker.sv
tb/decimal_text_checker.sv
tb/tb.sv
